// ----- hw/rtl/pcwc_pkg.sv -----
// ----------------------------------------------------------------------------
// pcwc_pkg: shared definitions for the portal column window clip unit
// Request kinds, sequencer states, row limits and field widths.
// ----------------------------------------------------------------------------
package pcwc_pkg;

    localparam int COLUMNS_DEFAULT = 1024;

    localparam int ROW_W   = 12;
    localparam int COL_W   = 10;
    localparam int FIX_W   = 28;
    localparam int ACC_W   = 40;
    localparam int FRAC_W  = 16;
    localparam int PROW_W  = ACC_W + 1 - FRAC_W;

    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 32;

    localparam logic signed [ROW_W-1:0] ROW_MAX = 12'sd2047;
    localparam logic signed [ROW_W-1:0] ROW_MIN = -12'sd2048;

    typedef logic signed [ROW_W-1:0]  row_t;
    typedef logic signed [FIX_W-1:0]  fix_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [PROW_W-1:0] prow_t;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_EDGE   = 2'd1,
        REQ_READ   = 2'd2,
        REQ_UNUSED = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_READ_RD,
        ST_READ_WAIT,
        ST_CEIL_RD,
        ST_CEIL_WR,
        ST_FLOOR_RD,
        ST_FLOOR_WR,
        ST_FINISH
    } state_t;

endpackage

// ----- hw/rtl/portal_column_window_clip_unit.sv -----
// ----------------------------------------------------------------------------
// portal_column_window_clip_unit: per-column portal window clipping
// Holds parent and next-level windows per column and narrows the next window
// along fixed-point ceiling and floor edges.
// ----------------------------------------------------------------------------
// Usage:
// Each request arrives as one transfer on the s_ channel; s_tuser carries the
// request kind (load, edge span, read) and s_tdata the remaining fields. Every
// request produces exactly one transfer on the m_ channel. Only a read returns
// a window; other requests return zero rows with done_res set.
// The block takes one request at a time: s_tready is high only while the
// sequencer is idle. The next request can be accepted at the edge at which the
// previous result can first transfer. Edge requests are paced by the single
// read and write port of the window memory: each column of each pass has a
// read state and a compute-and-write state, and the span is walked twice,
// ceiling then floor. The line position is kept in a 40-bit accumulator that
// adds the slope per column, so it stays exact.
// Reset clears the sequencer and the output valid flag; the column memories
// are not cleared, so a column must be loaded before it is read.
// When the receiver stalls, the result waits in the output register; the
// sequencer keeps working on the next request and holds only when it has a
// new result and the output register is still occupied.
// ----------------------------------------------------------------------------
module portal_column_window_clip_unit #(
    parameter int COLUMNS = pcwc_pkg::COLUMNS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata, from bit 0 up: column[9:0], load_top[21:10], load_bottom[33:22],
    // edge_x0[43:34], edge_x1[53:44], ceil_start[81:54], ceil_slope[109:82],
    // floor_start[137:110], floor_slope[165:138], zero fill[167:166]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pcwc_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser, from bit 0 up: req_type[1:0]
    input  logic [1:0]                      s_tuser,
    // m_tdata, from bit 0 up: next_top[11:0], next_bottom[23:12],
    // done_res[24], zero fill[31:25]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pcwc_pkg::M_TDATA_W-1:0]  m_tdata
);
    import pcwc_pkg::*;

    localparam int ADDR_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    // Column memories. Parent entries hold {bottom, top}; window entries the
    // same layout for the next-level window.
    logic [2*ROW_W-1:0] parent_mem [COLUMNS];
    logic [2*ROW_W-1:0] window_mem [COLUMNS];
    logic [2*ROW_W-1:0] parent_rd_reg;
    logic [2*ROW_W-1:0] window_rd_reg;

    // Unpacked input fields.
    logic [COL_W-1:0] in_column;
    row_t             in_load_top, in_load_bottom;
    logic [COL_W-1:0] in_x0, in_x1;
    fix_t             in_cs, in_cd, in_fs, in_fd;

    assign in_column      = s_tdata[9:0];
    assign in_load_top    = s_tdata[21:10];
    assign in_load_bottom = s_tdata[33:22];
    assign in_x0          = s_tdata[43:34];
    assign in_x1          = s_tdata[53:44];
    assign in_cs          = s_tdata[81:54];
    assign in_cd          = s_tdata[109:82];
    assign in_fs          = s_tdata[137:110];
    assign in_fd          = s_tdata[165:138];

    state_t state_reg, state_next;

    logic [COL_W-1:0] col_reg, x0_reg, x1_reg, x_reg;
    row_t             ltop_reg, lbot_reg;
    fix_t             cd_reg, fs_reg, fd_reg;
    acc_t             acc_reg;
    row_t             res_top_reg, res_bot_reg;
    logic             m_tvalid_reg;
    row_t             m_top_reg, m_bot_reg;

    // Memory port addressing: load and read requests use the request column,
    // the edge passes use the walking column.
    logic             use_col;
    logic [COL_W-1:0] cur_col;
    logic             in_range;
    logic [ADDR_W-1:0] mem_addr;

    assign use_col  = (state_reg == ST_LOAD) || (state_reg == ST_READ_RD)
                   || (state_reg == ST_READ_WAIT);
    assign cur_col  = use_col ? col_reg : x_reg;
    assign in_range = (32'(cur_col) < COLUMNS);
    assign mem_addr = in_range ? ADDR_W'(cur_col) : '0;

    // Rounded line row: floor((y + 0.5)), halves rounding upward.
    logic signed [ACC_W:0] rnd_sum;
    prow_t                 p_row;
    assign rnd_sum = {acc_reg[ACC_W-1], acc_reg} + (ACC_W+1)'(32768);
    assign p_row   = rnd_sum[ACC_W:FRAC_W];

    row_t  rd_ptop, rd_pbot, rd_ntop, rd_nbot;
    prow_t ptop_x, pbot_x, nbot_x;
    row_t  nbot_inc, ptop_dec;
    row_t  ceil_top, floor_bot;
    logic  ceil_hit, floor_hit;

    assign rd_ptop  = parent_rd_reg[ROW_W-1:0];
    assign rd_pbot  = parent_rd_reg[2*ROW_W-1:ROW_W];
    assign rd_ntop  = window_rd_reg[ROW_W-1:0];
    assign rd_nbot  = window_rd_reg[2*ROW_W-1:ROW_W];
    assign ptop_x   = PROW_W'(rd_ptop);
    assign pbot_x   = PROW_W'(rd_pbot);
    assign nbot_x   = PROW_W'(rd_nbot);

    // Clamp values saturate at the row limits.
    assign nbot_inc = (rd_nbot == ROW_MAX) ? ROW_MAX : row_t'(rd_nbot + 12'sd1);
    assign ptop_dec = (rd_ptop == ROW_MIN) ? ROW_MIN : row_t'(rd_ptop - 12'sd1);

    assign ceil_hit  = (p_row > ptop_x);
    assign ceil_top  = (p_row <= nbot_x) ? row_t'(p_row) : nbot_inc;
    assign floor_hit = (p_row < pbot_x);
    assign floor_bot = (p_row >= ptop_x) ? row_t'(p_row) : ptop_dec;

    logic pass_end;
    assign pass_end = (x_reg == x1_reg);

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (req_t'(s_tuser))
                        REQ_LOAD: state_next = ST_LOAD;
                        REQ_EDGE: state_next = (in_x0 <= in_x1) ? ST_CEIL_RD : ST_FINISH;
                        REQ_READ: state_next = ST_READ_RD;
                        default:  state_next = ST_FINISH;
                    endcase
                end
            end
            ST_LOAD:      state_next = ST_FINISH;
            ST_READ_RD:   state_next = ST_READ_WAIT;
            ST_READ_WAIT: state_next = ST_FINISH;
            ST_CEIL_RD:   state_next = ST_CEIL_WR;
            ST_CEIL_WR:   state_next = pass_end ? ST_FLOOR_RD : ST_CEIL_RD;
            ST_FLOOR_RD:  state_next = ST_FLOOR_WR;
            ST_FLOOR_WR:  state_next = pass_end ? ST_FINISH : ST_FLOOR_RD;
            ST_FINISH:    state_next = out_free ? ST_IDLE : ST_FINISH;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Output and memory-control logic.
    logic             parent_we, window_we;
    logic [2*ROW_W-1:0] parent_wdata, window_wdata;

    always_comb begin
        s_tready     = 1'b0;
        parent_we    = 1'b0;
        window_we    = 1'b0;
        parent_wdata = {lbot_reg, ltop_reg};
        window_wdata = {lbot_reg, ltop_reg};
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_LOAD: begin
                parent_we = in_range;
                window_we = in_range;
            end
            ST_CEIL_WR: begin
                window_we    = in_range && ceil_hit;
                window_wdata = {rd_nbot, ceil_top};
            end
            ST_FLOOR_WR: begin
                window_we    = in_range && floor_hit;
                window_wdata = {floor_bot, rd_ntop};
            end
            default: ;
        endcase
    end

    // Column memories: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (parent_we) begin
            parent_mem[mem_addr] <= parent_wdata;
        end
        if (window_we) begin
            window_mem[mem_addr] <= window_wdata;
        end
        parent_rd_reg <= parent_mem[mem_addr];
        window_rd_reg <= window_mem[mem_addr];
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FINISH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    col_reg     <= in_column;
                    ltop_reg    <= in_load_top;
                    lbot_reg    <= in_load_bottom;
                    x0_reg      <= in_x0;
                    x1_reg      <= in_x1;
                    x_reg       <= in_x0;
                    cd_reg      <= in_cd;
                    fs_reg      <= in_fs;
                    fd_reg      <= in_fd;
                    acc_reg     <= ACC_W'(in_cs);
                    res_top_reg <= '0;
                    res_bot_reg <= '0;
                end
            end
            ST_READ_WAIT: begin
                if (in_range) begin
                    res_top_reg <= rd_ntop;
                    res_bot_reg <= rd_nbot;
                end
            end
            ST_CEIL_WR: begin
                if (pass_end) begin
                    x_reg   <= x0_reg;
                    acc_reg <= ACC_W'(fs_reg);
                end else begin
                    x_reg   <= x_reg + COL_W'(1);
                    acc_reg <= acc_reg + ACC_W'(cd_reg);
                end
            end
            ST_FLOOR_WR: begin
                x_reg   <= x_reg + COL_W'(1);
                acc_reg <= acc_reg + ACC_W'(fd_reg);
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_top_reg <= res_top_reg;
                    m_bot_reg <= res_bot_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, 1'b1, m_bot_reg, m_top_reg};

endmodule
